>>> src/ftr_pkg.sv
// ----------------------------------------------------------------------------
// ftr_pkg
// shared codes and widths of the filled triangle rasterizer
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int COLOR_BITS = 32;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

endpackage

>>> src/ftr_queue.sv
// ----------------------------------------------------------------------------
// ftr_queue
// two-entry item queue between the input port and the rasterizer engine
// ----------------------------------------------------------------------------
module ftr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/ftr_div.sv
// ----------------------------------------------------------------------------
// ftr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftr_div #(
  parameter int NUM_BITS = 28,
  parameter int DEN_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS:0]   rem_shift;
  logic [DEN_BITS-1:0] den;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                fits;

  assign rem_shift = {rem[DEN_BITS-1:0], quotient[NUM_BITS-1]};
  assign fits      = (rem_shift >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      den      <= divisor;
    end else if (busy) begin
      rem      <= fits ? (rem_shift - {1'b0, den}) : rem_shift;
      quotient <= {quotient[NUM_BITS-2:0], fits};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_BITS'(NUM_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(NUM_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/ftr_engine.sv
// ----------------------------------------------------------------------------
// ftr_engine
// triangle set-up, row walking and pixel emission
// ----------------------------------------------------------------------------
module ftr_engine import ftr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         item_func,
  input  logic signed [COORD_BITS-1:0] item_x0,
  input  logic signed [COORD_BITS-1:0] item_y0,
  input  logic signed [COORD_BITS-1:0] item_x1,
  input  logic signed [COORD_BITS-1:0] item_y1,
  input  logic signed [COORD_BITS-1:0] item_x2,
  input  logic signed [COORD_BITS-1:0] item_y2,
  input  logic [COLOR_BITS-1:0]        item_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         pixel_valid,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         last_pixel
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int W  = C + F + 2;
  localparam int SW = C + F + 1;
  localparam int DN = C + F;
  localparam int PW = C + 1 + SW;
  localparam logic signed [W-1:0] ONE = W'(1) <<< F;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIVGO   = 4'd1;
  localparam logic [3:0] ST_DIVWAIT = 4'd2;
  localparam logic [3:0] ST_MULA    = 4'd3;
  localparam logic [3:0] ST_MULB    = 4'd4;
  localparam logic [3:0] ST_MULC    = 4'd5;
  localparam logic [3:0] ST_INIT    = 4'd6;
  localparam logic [3:0] ST_SEEK    = 4'd7;
  localparam logic [3:0] ST_READY   = 4'd8;

  logic [3:0] st;

  logic signed [C-1:0]  sx0, sy0, sx1, sy1, sx2, sy2;
  logic [COLOR_BITS-1:0] color;
  logic signed [SW-1:0] slope01, slope12, slope02, short_s;
  logic [1:0]           kidx;
  logic signed [W-1:0]  long_v, short_v, cur_x, long_m, short_m;
  logic signed [PW-1:0] prod;
  logic                 lel;
  logic signed [C-1:0]  row;
  logic                 pend;
  logic signed [C-1:0]  pend_px, pend_py;

  // sorting of the incoming vertices
  logic signed [C-1:0] ax1, ay1, bx1, by1;
  logic signed [C-1:0] ax2, ay2, cx2, cy2;
  logic signed [C-1:0] bx3, by3, cx3, cy3;

  always_comb begin
    if (item_y1 < item_y0) begin
      ax1 = item_x1; ay1 = item_y1; bx1 = item_x0; by1 = item_y0;
    end else begin
      ax1 = item_x0; ay1 = item_y0; bx1 = item_x1; by1 = item_y1;
    end
    if (item_y2 < ay1) begin
      ax2 = item_x2; ay2 = item_y2; cx2 = ax1; cy2 = ay1;
    end else begin
      ax2 = ax1; ay2 = ay1; cx2 = item_x2; cy2 = item_y2;
    end
    if (cy2 < by1) begin
      bx3 = cx2; by3 = cy2; cx3 = bx1; cy3 = by1;
    end else begin
      bx3 = bx1; by3 = by1; cx3 = cx2; cy3 = cy2;
    end
  end

  // edge operands for the divider
  logic signed [C-1:0] xa, ya, xb, yb;
  logic signed [C:0]   ddx, ddy;
  logic [C-1:0]        adx;
  logic                div_start, div_done;
  logic [DN-1:0]       div_q;
  logic signed [SW-1:0] q_signed;

  always_comb begin
    unique case (kidx)
      2'd0:    begin xa = sx0; ya = sy0; xb = sx1; yb = sy1; end
      2'd1:    begin xa = sx1; ya = sy1; xb = sx2; yb = sy2; end
      default: begin xa = sx0; ya = sy0; xb = sx2; yb = sy2; end
    endcase
  end

  assign ddx = (C+1)'(xb) - (C+1)'(xa);
  assign ddy = (C+1)'(yb) - (C+1)'(ya);
  assign adx = ddx[C] ? C'(-ddx) : ddx[C-1:0];
  assign q_signed = ddx[C] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign div_start = (st == ST_DIVGO) && (ddy != '0);

  ftr_div #(.NUM_BITS(DN), .DEN_BITS(C)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({adx, {F{1'b0}}}),
    .divisor  (ddy[C-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // mid-row compare operands
  logic signed [C:0]   d01, d02;
  logic [C:0]          m_sum;
  logic [C-1:0]        m_val, m_short;
  logic                m_first;
  logic signed [W-1:0] x0f, x1f;

  assign d01     = (C+1)'(sy1) - (C+1)'(sy0);
  assign d02     = (C+1)'(sy2) - (C+1)'(sy0);
  assign m_sum   = d02 + 1'b1;
  assign m_val   = m_sum[C:1];
  assign m_first = ({1'b0, m_val} < d01);
  assign m_short = m_val - d01[C-1:0];
  assign x0f     = {{(W-C-F){sx0[C-1]}}, sx0, {F{1'b0}}};
  assign x1f     = {{(W-C-F){sx1[C-1]}}, sx1, {F{1'b0}}};

  // row walking
  logic signed [W-1:0] left_x, right_x, long_n, short_n, left_n, x_inc;
  logic signed [SW-1:0] short_s_n;
  logic signed [C-1:0]  row_n;
  logic signed [W-1:0]  x_int;
  logic signed [C-1:0]  px;
  logic                 out_free, take, lel_init, emit;
  logic signed [W-1:0]  short_init;

  assign left_x  = lel ? long_v : short_v;
  assign right_x = lel ? short_v : long_v;
  assign row_n   = row + 1'b1;
  assign long_n  = long_v + W'(slope02);

  always_comb begin
    if (row_n == sy1) begin
      short_n   = x1f;
      short_s_n = slope12;
    end else begin
      short_n   = short_v + W'(short_s);
      short_s_n = short_s;
    end
  end

  assign left_n     = lel ? long_n : short_n;
  assign x_inc      = cur_x + ONE;
  assign x_int      = (cur_x >>> F) + W'(cur_x[W-1] && (cur_x[F-1:0] != '0));
  assign px         = x_int[C-1:0];
  assign out_free   = !out_valid || !out_stall;
  assign item_stall = !(((st == ST_IDLE) || (st == ST_READY)) && out_free);
  assign take       = item_valid && !item_stall;
  assign lel_init   = (long_m < short_m);
  assign short_init = (d01 != '0) ? x0f : x1f;

  // a new result is loaded into the output register
  assign emit = (take && (item_func == FUNC_ADVANCE)
                 && ((st == ST_IDLE) || (x_inc <= right_x) || (row == sy2)))
             || ((st == ST_SEEK) && pend && out_free
                 && ((cur_x <= right_x) || (row == sy2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      kidx      <= 2'd0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      unique case (st)
        ST_IDLE, ST_READY: begin
          if (take) begin
            if (item_func == FUNC_START) begin
              sx0 <= ax2; sy0 <= ay2; sx1 <= bx3; sy1 <= by3; sx2 <= cx3; sy2 <= cy3;
              color <= item_color;
              kidx  <= 2'd0;
              st    <= ST_DIVGO;
            end else if (st == ST_IDLE) begin
              pixel_valid <= 1'b0;
              pixel_x     <= '0;
              pixel_y     <= '0;
              pixel_color <= '0;
              last_pixel  <= 1'b0;
            end else if (x_inc <= right_x) begin
              pixel_valid <= 1'b1;
              pixel_x     <= px;
              pixel_y     <= row;
              pixel_color <= color;
              last_pixel  <= 1'b0;
              cur_x       <= x_inc;
            end else if (row == sy2) begin
              pixel_valid <= 1'b1;
              pixel_x     <= px;
              pixel_y     <= row;
              pixel_color <= color;
              last_pixel  <= 1'b1;
              st          <= ST_IDLE;
            end else begin
              pend    <= 1'b1;
              pend_px <= px;
              pend_py <= row;
              cur_x   <= x_inc;
              st      <= ST_SEEK;
            end
          end
        end
        ST_DIVGO: begin
          if (ddy == '0) begin
            unique case (kidx)
              2'd0:    slope01 <= '0;
              2'd1:    slope12 <= '0;
              default: slope02 <= '0;
            endcase
            if (kidx == 2'd2) st <= ST_MULA;
            else kidx <= kidx + 2'd1;
          end else begin
            st <= ST_DIVWAIT;
          end
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            unique case (kidx)
              2'd0:    slope01 <= q_signed;
              2'd1:    slope12 <= q_signed;
              default: slope02 <= q_signed;
            endcase
            if (kidx == 2'd2) begin
              st <= ST_MULA;
            end else begin
              kidx <= kidx + 2'd1;
              st   <= ST_DIVGO;
            end
          end
        end
        ST_MULA: begin
          prod <= $signed({1'b0, m_val}) * slope02;
          st   <= ST_MULB;
        end
        ST_MULB: begin
          long_m <= x0f + prod[W-1:0];
          prod   <= m_first ? $signed({1'b0, m_val}) * slope01
                            : $signed({1'b0, m_short}) * slope12;
          st     <= ST_MULC;
        end
        ST_MULC: begin
          short_m <= (m_first ? x0f : x1f) + prod[W-1:0];
          st      <= ST_INIT;
        end
        ST_INIT: begin
          lel     <= lel_init;
          long_v  <= x0f;
          short_v <= short_init;
          short_s <= (d01 != '0) ? slope01 : slope12;
          row     <= sy0;
          cur_x   <= lel_init ? x0f : short_init;
          pend    <= 1'b0;
          st      <= ST_SEEK;
        end
        ST_SEEK: begin
          if (cur_x <= right_x) begin
            if (!pend) begin
              st <= ST_READY;
            end else if (out_free) begin
              pixel_valid <= 1'b1;
              pixel_x     <= pend_px;
              pixel_y     <= pend_py;
              pixel_color <= color;
              last_pixel  <= 1'b0;
              pend        <= 1'b0;
              st          <= ST_READY;
            end
          end else if (row == sy2) begin
            if (!pend) begin
              st <= ST_IDLE;
            end else if (out_free) begin
              pixel_valid <= 1'b1;
              pixel_x     <= pend_px;
              pixel_y     <= pend_py;
              pixel_color <= color;
              last_pixel  <= 1'b1;
              pend        <= 1'b0;
              st          <= ST_IDLE;
            end
          end else begin
            row     <= row_n;
            long_v  <= long_n;
            short_v <= short_n;
            short_s <= short_s_n;
            cur_x   <= left_n;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/filled_triangle_rasterizer.sv
// ----------------------------------------------------------------------------
// filled_triangle_rasterizer
// flat-fill triangle rasterizer, one result per advance transaction
// ----------------------------------------------------------------------------
// set-up: the serial slope divider computes the edge slopes in turn
// advance within a row: one pixel per cycle unless out_stall holds; rows change in ST_SEEK
// an accepted advance waits in the queue; its result is then loaded into the output register
// a two-entry queue takes input transactions while the engine is busy
// synchronous active-high reset: idle, queue and output register empty
module filled_triangle_rasterizer import ftr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] vert0_x,
  input  logic signed [COORD_BITS-1:0] vert0_y,
  input  logic signed [COORD_BITS-1:0] vert1_x,
  input  logic signed [COORD_BITS-1:0] vert1_y,
  input  logic signed [COORD_BITS-1:0] vert2_x,
  input  logic signed [COORD_BITS-1:0] vert2_y,
  input  logic [COLOR_BITS-1:0]        fill_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         pixel_valid,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         last_pixel
);

  localparam int IW = 1 + 6 * COORD_BITS + COLOR_BITS;

  logic [IW-1:0]         q_data;
  logic                  q_valid, q_stall;
  logic                  q_func;
  logic [COORD_BITS-1:0] q_x0, q_y0, q_x1, q_y1, q_x2, q_y2;
  logic [COLOR_BITS-1:0] q_color;

  ftr_queue #(.WIDTH(IW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_stall (in_stall),
    .wr_data  ({func, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, fill_color}),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_data)
  );

  assign {q_func, q_x0, q_y0, q_x1, q_y1, q_x2, q_y2, q_color} = q_data;

  ftr_engine #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (q_valid),
    .item_stall  (q_stall),
    .item_func   (q_func),
    .item_x0     ($signed(q_x0)),
    .item_y0     ($signed(q_y0)),
    .item_x1     ($signed(q_x1)),
    .item_y1     ($signed(q_y1)),
    .item_x2     ($signed(q_x2)),
    .item_y2     ($signed(q_y2)),
    .item_color  (q_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule

>>> src/ftr_checker.sv
// ----------------------------------------------------------------------------
// ftr_checker
// port-level checks of the filled triangle rasterizer
// ----------------------------------------------------------------------------
module ftr_checker import ftr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         func,
  input logic signed [COORD_BITS-1:0] vert0_x,
  input logic signed [COORD_BITS-1:0] vert0_y,
  input logic signed [COORD_BITS-1:0] vert1_x,
  input logic signed [COORD_BITS-1:0] vert1_y,
  input logic signed [COORD_BITS-1:0] vert2_x,
  input logic signed [COORD_BITS-1:0] vert2_y,
  input logic [COLOR_BITS-1:0]        fill_color,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         pixel_valid,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS-1:0] pixel_y,
  input logic [COLOR_BITS-1:0]        pixel_color,
  input logic                         last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled transaction changed");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> !last_pixel && pixel_x == '0 && pixel_y == '0
      && pixel_color == '0)
    else $error("idle result not all zero");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> pixel_valid)
    else $error("last pixel without pixel");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output after reset");

endmodule

bind filled_triangle_rasterizer ftr_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_ftr_checker (.*);
